FILE: rtl/pfrf_pkg.sv
`timescale 1ns / 1ps

package pfrf_pkg;

  localparam int ScreenColumns = 128;
  localparam int ScreenRows    = 32;
  localparam int PageCount     = (ScreenRows + 7) / 8;
  localparam int ColWidth      = $clog2(ScreenColumns);
  localparam int WordWidth     = PageCount * 8;
  // signed coordinate width, wide enough for 256 and for start plus one
  localparam int CoordWidth    = 10;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic issue_fill;
    logic issue_read;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dp_stat_t;

endpackage

FILE: rtl/page_framebuffer_rect_fill.sv
`timescale 1ns / 1ps

// monochrome page frame store, 128 columns by 32 rows, kept as one 32-bit word per column
// (byte n of a word is page n, bit b of that byte is row 8*n+b). each input beat is one
// command: set pixel, fill rectangle, clear store, read byte; each gives exactly one output
// beat, the addressed byte for a read and zero otherwise. one command is worked at a time:
// a fill does one read-modify-write per column through the column memory, with one read
// port and one write port, reads and writes of neighboring columns overlapped. the exclusive
// right bound tops out at 127, so a fill covers at most 127 columns. a stalled output beat
// holds the next result back in the done state until the beat is taken.
// a per-column valid bit makes reset and clear act at once, with no clearing pass.
// a finished result sits in the output register while the next command is accepted.

module page_framebuffer_rect_fill import pfrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] end_x_i,
  input  logic [7:0] end_y_i,
  input  logic [6:0] read_column_i,
  input  logic [1:0] read_page_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: idle, column walk, read, clear, result hand-off
  pfrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_e'(cmd_i)),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .dp_cmd_o   (dp_cmd),
    .dp_stat_i  (dp_stat)
  );

  // clipping, row mask, column memory and result register
  pfrf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .dp_stat_o    (dp_stat),
    .cmd_i        (cmd_e'(cmd_i)),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .read_column_i(read_column_i),
    .read_page_i  (read_page_i),
    .read_data_o  (read_data_o)
  );

endmodule

FILE: rtl/pfrf_ctrl.sv
`timescale 1ns / 1ps

module pfrf_ctrl import pfrf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cmd_e     cmd_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output dp_cmd_t  dp_cmd_o,
  input  dp_stat_t dp_stat_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FILL  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          case (cmd_i)
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_READ:  state_d = ST_READ;
            default:   state_d = ST_FILL;
          endcase
        end
      end
      ST_FILL: begin
        if (dp_stat_i.empty) begin
          state_d = ST_DONE;
        end else begin
          dp_cmd_o.issue_fill = 1'b1;
          if (dp_stat_i.last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        dp_cmd_o.issue_read = 1'b1;
        state_d             = ST_DONE;
      end
      ST_CLEAR: begin
        dp_cmd_o.clear = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.res_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pfrf_datapath.sv
`timescale 1ns / 1ps

module pfrf_datapath import pfrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    dp_cmd_i,
  output dp_stat_t   dp_stat_o,
  input  cmd_e       cmd_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] end_x_i,
  input  logic [7:0] end_y_i,
  input  logic [6:0] read_column_i,
  input  logic [1:0] read_page_i,
  output logic [7:0] read_data_o
);

  localparam logic signed [CoordWidth-1:0] ColsS = CoordWidth'(ScreenColumns);
  localparam logic signed [CoordWidth-1:0] RowsS = CoordWidth'(ScreenRows);
  localparam logic signed [CoordWidth-1:0] OneS  = CoordWidth'(1);

  // column-wide words, one per screen column, all pages together
  logic [WordWidth-1:0]     mem_q [ScreenColumns];
  logic [ScreenColumns-1:0] colv_q;
  logic [WordWidth-1:0]     rdata_q;
  logic                     hit_q;
  logic                     wr_pend_q;
  logic [ColWidth-1:0]      wr_addr_q;

  logic [ColWidth-1:0]  col_q, col_d;
  logic [ColWidth-1:0]  last_q, last_d;
  logic [WordWidth-1:0] mask_q, mask_d;
  logic                 empty_q, empty_d;
  logic                 is_read_q;
  logic                 rd_ok_q, rd_ok_d;
  logic [1:0]           page_q;
  logic [7:0]           out_data_q;

  logic signed [CoordWidth-1:0] x0, y0, x1, y1, xe, ye, xl;
  logic [8:0]                   rcol;
  logic [WordWidth-1:0]         merged;
  logic [7:0]                   rbyte;
  logic                         rd_en;

  // operand decode: a set pixel is a one by one rectangle
  always_comb begin
    x0 = CoordWidth'($signed(start_x_i));
    y0 = CoordWidth'($signed(start_y_i));
    if (cmd_i == CMD_SET) begin
      x1 = x0 + OneS;
      y1 = y0 + OneS;
    end else begin
      x1 = CoordWidth'($signed(end_x_i));
      y1 = CoordWidth'($signed(end_y_i));
    end
    xe = (x1 > ColsS) ? ColsS : x1;
    ye = (y1 > RowsS) ? RowsS : y1;
    xl = xe - OneS;
    empty_d = (x1 < x0) || (y1 < y0) || (x0 < 0) || (y0 < 0) || (x0 >= xe) || (y0 >= ye);
    mask_d = '0;
    for (int r = 0; r < ScreenRows; r++) begin
      mask_d[r] = ($signed(CoordWidth'(r)) >= y0) && ($signed(CoordWidth'(r)) < ye);
    end
    rcol    = {2'b00, read_column_i};
    rd_ok_d = (rcol < 9'(ScreenColumns)) && (int'(read_page_i) < PageCount);
    if (cmd_i == CMD_READ) begin
      col_d = rcol[ColWidth-1:0];
    end else begin
      col_d = x0[ColWidth-1:0];
    end
    last_d = xl[ColWidth-1:0];
  end

  assign rd_en  = dp_cmd_i.issue_fill || dp_cmd_i.issue_read;
  assign merged = (hit_q ? rdata_q : '0) | mask_q;

  always_comb begin
    rbyte = '0;
    for (int p = 0; p < PageCount; p++) begin
      if (int'(page_q) == p) begin
        rbyte = rdata_q[p*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= merged;
    end
    if (rd_en) begin
      rdata_q <= mem_q[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colv_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= dp_cmd_i.issue_fill;
      if (dp_cmd_i.clear) begin
        colv_q <= '0;
      end else if (wr_pend_q) begin
        colv_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      col_q     <= col_d;
      last_q    <= last_d;
      mask_q    <= mask_d;
      empty_q   <= empty_d;
      is_read_q <= (cmd_i == CMD_READ);
      rd_ok_q   <= rd_ok_d;
      page_q    <= read_page_i;
    end else if (dp_cmd_i.issue_fill) begin
      col_q <= col_q + ColWidth'(1);
    end
    if (rd_en) begin
      hit_q     <= colv_q[col_q];
      wr_addr_q <= col_q;
    end
    if (dp_cmd_i.res_load) begin
      out_data_q <= (is_read_q && rd_ok_q && hit_q) ? rbyte : '0;
    end
  end

  assign dp_stat_o.empty = empty_q;
  assign dp_stat_o.last  = (col_q == last_q);
  assign read_data_o     = out_data_q;

endmodule

FILE: rtl/pfrf_checker.sv
`timescale 1ns / 1ps

module pfrf_checker import pfrf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] cmd_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  // a stalled output beat holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("output beat dropped or changed while stalled");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o)
    else $error("input taken while a command is in flight");

  // no result appears in the cycle right after accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // clear accepted with a free output slot answers with a zero beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (cmd_i == CMD_CLEAR) && !out_valid_o |-> ##3 (out_valid_o && read_data_o == 8'd0))
    else $error("clear did not return a zero beat");

endmodule

bind page_framebuffer_rect_fill pfrf_checker u_pfrf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .read_data_o(read_data_o)
);

FILE: tb/page_framebuffer_rect_fill_tb.sv
`timescale 1ns / 1ps

module page_framebuffer_rect_fill_tb;
  import pfrf_pkg::*;

  // one command beat as the sender holds it
  typedef struct {
    cmd_e       op;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    logic [6:0] col;
    logic [1:0] page;
  } fb_cmd_t;

  localparam int IdleLimit    = 4000;  // cycles with no beat on either side
  localparam int RandomCmds   = 1400;
  localparam int HoldOffAt    = 300;   // results seen before the long receiver hold-off
  localparam int HoldOffLen   = 600;
  localparam int DrainCycles  = 200;   // quiet tail after the last result, to catch stray beats

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd_q = '0;
  logic [7:0] start_x_q = '0;
  logic [7:0] start_y_q = '0;
  logic [7:0] end_x_q = '0;
  logic [7:0] end_y_q = '0;
  logic [6:0] read_column_q = '0;
  logic [1:0] read_page_q = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;

  fb_cmd_t    cmd_backlog[$];     // commands not yet offered
  logic [7:0] expected_bytes[$];  // predicted read_data, oldest first
  logic [7:0] shadow_fb[ScreenColumns][PageCount];
  int         err_count = 0;
  int         total_cmds = 0;     // every command gives one result beat

  always #5 clk_i = ~clk_i;

  page_framebuffer_rect_fill u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd_q),
    .start_x_i    (start_x_q),
    .start_y_i    (start_y_q),
    .end_x_i      (end_x_q),
    .end_y_i      (end_y_q),
    .read_column_i(read_column_q),
    .read_page_i  (read_page_q),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data)
  );

  // ---------------------------------------------------------------------------
  // predictor: shadow copy of the frame store
  // ---------------------------------------------------------------------------

  // or in one pixel, anything off screen is dropped
  function automatic void shadow_plot(int x, int y);
    if (x >= 0 && x < ScreenColumns && y >= 0 && y < ScreenRows) begin
      shadow_fb[x][y / 8] |= 8'(1 << (y % 8));
    end
  endfunction

  function automatic void shadow_clear();
    for (int x = 0; x < ScreenColumns; x++) begin
      for (int p = 0; p < PageCount; p++) begin
        shadow_fb[x][p] = '0;
      end
    end
  endfunction

  // applies one command to the shadow store, returns the byte the block must send
  function automatic logic [7:0] draw_and_read(fb_cmd_t c);
    int         x0;
    int         y0;
    int         x1;
    int         y1;
    int         xe;
    int         ye;
    logic [7:0] rd;
    x0 = int'($signed(c.sx));
    y0 = int'($signed(c.sy));
    x1 = int'($signed(c.ex));
    y1 = int'($signed(c.ey));
    rd = '0;
    case (c.op)
      CMD_SET: begin
        shadow_plot(x0, y0);
      end
      CMD_FILL: begin
        // negative start or reversed bounds draw nothing; the far edges clip to the screen
        if (!(x1 < x0 || y1 < y0 || x0 < 0 || y0 < 0)) begin
          xe = (x1 < ScreenColumns) ? x1 : ScreenColumns;
          ye = (y1 < ScreenRows) ? y1 : ScreenRows;
          for (int x = x0; x < xe; x++) begin
            for (int y = y0; y < ye; y++) begin
              shadow_plot(x, y);
            end
          end
        end
      end
      CMD_CLEAR: begin
        shadow_clear();
      end
      default: begin
        if (int'(c.col) < ScreenColumns && int'(c.page) < PageCount) begin
          rd = shadow_fb[c.col][c.page];
        end
      end
    endcase
    return rd;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------

  function automatic fb_cmd_t mk_cmd(cmd_e op, int sx, int sy, int ex, int ey,
                                     int col, int page);
    fb_cmd_t c;
    c.op   = op;
    c.sx   = 8'(sx);
    c.sy   = 8'(sy);
    c.ex   = 8'(ex);
    c.ey   = 8'(ey);
    c.col  = 7'(col);
    c.page = 2'(page);
    return c;
  endfunction

  // mostly well-formed pixels and rectangles on screen, plus clears, reads and raw noise in the operand fields
  function automatic fb_cmd_t random_cmd();
    fb_cmd_t     c;
    int unsigned r;
    int          sx;
    int          sy;
    int          w;
    int          h;
    c.sx   = 8'($urandom);
    c.sy   = 8'($urandom);
    c.ex   = 8'($urandom);
    c.ey   = 8'($urandom);
    c.col  = 7'($urandom);
    c.page = 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      c.op = CMD_SET;
      if ($urandom_range(0, 9) < 8) begin
        c.sx = 8'($urandom_range(0, ScreenColumns - 1));
        c.sy = 8'($urandom_range(0, ScreenRows - 1));
      end
    end else if (r < 55) begin
      c.op = CMD_FILL;
      if ($urandom_range(0, 99) < 85) begin
        sx = $urandom_range(0, 126);
        sy = $urandom_range(0, ScreenRows - 1);
        // keep most rectangles narrow so the run stays short, a few span the screen
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127 - sx)
                                         : $urandom_range(0, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127 - sy)
                                        : $urandom_range(0, ScreenRows - sy);
        c.sx = 8'(sx);
        c.sy = 8'(sy);
        c.ex = 8'((sx + w > 127) ? 127 : sx + w);
        c.ey = 8'(sy + h);
      end
    end else if (r < 57) begin
      c.op = CMD_CLEAR;
    end else begin
      c.op = CMD_READ;
    end
    return c;
  endfunction

  // random gap length, mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers the backlog, holds each beat until it is taken
  // ---------------------------------------------------------------------------

  int      in_gap = 0;
  int      in_calm = 0;   // beats left in a stretch without gaps
  fb_cmd_t offered;

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      cmd_q         <= '0;
      start_x_q     <= '0;
      start_y_q     <= '0;
      end_x_q       <= '0;
      end_y_q       <= '0;
      read_column_q <= '0;
      read_page_q   <= '0;
    end else begin
      // beat taken: predict now, commands are worked in order
      if (in_valid && in_ready) begin
        expected_bytes.push_back(draw_and_read(offered));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   = in_gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          offered = cmd_backlog.pop_front();
          in_valid      <= 1'b1;
          cmd_q         <= offered.op;
          start_x_q     <= offered.sx;
          start_y_q     <= offered.sy;
          end_x_q       <= offered.ex;
          end_y_q       <= offered.ey;
          read_column_q <= offered.col;
          read_page_q   <= offered.page;
          // now and then a back-to-back stretch
          if (in_calm > 0) begin
            in_calm = in_calm - 1;
          end else if ($urandom_range(0, 49) == 0) begin
            in_calm = $urandom_range(20, 60);
          end else begin
            in_gap = pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each result beat, stalls at random
  // ---------------------------------------------------------------------------

  int         results_seen = 0;
  int         out_stall = 0;
  int         hold_off = 0;
  bit         hold_done = 1'b0;
  logic [7:0] want;

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %02h",
                   $time, read_data);
          err_count = err_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (read_data !== want) begin
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want, read_data);
            err_count = err_count + 1;
          end
        end
      end
      // one long hold-off so the output register fills and the input backs up
      if (!hold_done && results_seen >= HoldOffAt) begin
        hold_done = 1'b1;
        hold_off  = HoldOffLen;
      end
      if (hold_off > 0) begin
        hold_off = hold_off - 1;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall = out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          out_stall = pick_gap();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no beat on either side ends the run
  // ---------------------------------------------------------------------------

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("page_framebuffer_rect_fill_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // backlog, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    shadow_clear();

    // directed: empty store, off-screen pixels, corner pixels
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SET, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SET, 127, 31, -1, -1, 127, 3));
    cmd_backlog.push_back(mk_cmd(CMD_SET, -1, 5, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SET, 5, -1, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SET, -128, 127, 127, -128, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SET, 127, 32, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, -1, -1, -1, -1, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 127, 3));
    // rectangles that draw nothing: negative start, reversed, empty
    cmd_backlog.push_back(mk_cmd(CMD_FILL, -1, 0, 10, 10, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 0, -1, 10, 10, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 10, 10, 5, 20, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 10, 10, 20, 5, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 20, 3, 20, 30, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 10, 1));
    // clipped on the bottom, then the widest fill
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 60, 30, 127, 127, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 126, 3));
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 0, 0, 127, 127, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 64, 2));
    // clear, then partial bytes across a page boundary
    cmd_backlog.push_back(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 127, 3));
    cmd_backlog.push_back(mk_cmd(CMD_FILL, 3, 5, 4, 14, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 3, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 3, 1));
    cmd_backlog.push_back(mk_cmd(CMD_SET, 100, 17, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 100, 2));

    for (int i = 0; i < RandomCmds; i++) begin
      cmd_backlog.push_back(random_cmd());
    end
    total_cmds = cmd_backlog.size();

    // release away from the rising edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // one result beat per command, then a quiet tail for stray beats
    while (results_seen < total_cmds) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("page_framebuffer_rect_fill_tb passed");
    end else begin
      $display("page_framebuffer_rect_fill_tb failed");
    end
    $finish;
  end

endmodule
